// ===== hdl/scd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    localparam int DELAY_FRAMES_DEF = 2048;
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int MAX_VOICES_DEF   = 3;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 2;
    localparam int GAIN_W     = 15;
    localparam int MEDIAN_W   = 11;
    localparam int SWING_W    = 10;
    localparam int PHASE_W    = 32;
    localparam int NUM_RATES  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 4 * SAMPLE_W;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    localparam logic [COUNT_W-1:0]  VOICE_COUNT_RST = 2'd2;
    localparam logic [GAIN_W-1:0]   VOICE_GAIN_RST  = 15'd16384;
    localparam logic [MEDIAN_W-1:0] MEDIAN_RST      = 11'd1102;
    localparam logic [SWING_W-1:0]  SWING_RST       = 10'd220;
    localparam logic [PHASE_W-1:0]  RATE_RST [NUM_RATES] = '{
        32'd29218, 32'd48696, 32'd14609
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOICE_COUNT = 3'd0,
        REG_VOICE_GAIN  = 3'd1,
        REG_MEDIAN      = 3'd2,
        REG_SWING       = 3'd3,
        REG_RATE_V0     = 3'd4,
        REG_RATE_V1     = 3'd5,
        REG_RATE_V2     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/stereo_chorus_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                      Word
// s_axis       in         s_axis_tvalid / s_axis_tready  in_left, in_right, base_left, base_right
// m_axis       out        m_axis_tvalid / m_axis_tready  out_left, out_right
// cfg          in         i_cfg_we (no ready)            register index, write data
//
// A frame is accepted only in the idle state, and the next one only after its result is
// loaded into the output register: one voice a cycle enters a seven-stage voice pipeline
// around the delay store read port, then the sum is rounded and saturated.
// Reset is synchronous; the delay store needs no clearing pass, a fill count masks
// frames not yet written. A stalled output holds its word while the next frame is
// taken; the block waits only when a second result is ready before the first leaves.

module stereo_chorus_delay #(
    parameter int DELAY_FRAMES = scd_pkg::DELAY_FRAMES_DEF,
    parameter int SINE_ENTRIES = scd_pkg::SINE_ENTRIES_DEF,
    parameter int MAX_VOICES   = scd_pkg::MAX_VOICES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // in_left, in_right, base_left, base_right
    input  wire logic [scd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_left, out_right
    output logic [scd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int SW       = scd_pkg::SAMPLE_W;
    localparam int AW       = $clog2(DELAY_FRAMES);
    localparam int FW       = $clog2(DELAY_FRAMES + 1);
    localparam int YW       = $clog2(5 * DELAY_FRAMES);
    localparam int OFFS3    = 3 * DELAY_FRAMES;
    localparam int OFFS4    = 4 * DELAY_FRAMES;
    localparam int OFFS2    = 2 * DELAY_FRAMES;
    localparam int SIW      = $clog2(SINE_ENTRIES);
    localparam int SPW      = scd_pkg::PHASE_W + SIW;
    localparam int VW       = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int PH_DEPTH = 1 << VW;
    localparam int ACC_W    = 32 + $clog2(MAX_VOICES + 1);
    localparam int SHW      = ACC_W - 15;
    localparam int DW       = scd_pkg::MEDIAN_W + 17;
    localparam int PRW      = scd_pkg::SWING_W + SW + 1;

    typedef struct packed {
        logic          vld;
        logic          act;
        logic          last;
        logic [VW-1:0] voice;
    } t_tok;

    // configuration
    logic [scd_pkg::COUNT_W-1:0]  r_vcount;
    logic [scd_pkg::GAIN_W-1:0]   r_gain;
    logic [scd_pkg::MEDIAN_W-1:0] r_median;
    logic [scd_pkg::SWING_W-1:0]  r_swing;
    logic [scd_pkg::PHASE_W-1:0]  r_rate [scd_pkg::NUM_RATES];

    // control
    scd_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_wp, n_wp;
    logic [FW-1:0]   r_fill;
    logic [VW-1:0]   r_iss;
    logic            r_iss_on;
    t_tok            r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    logic            r_fin;
    logic            r_ovld;
    logic [PH_DEPTH-1:0] r_ph_vld;

    // stores
    logic [2*SW-1:0]              r_dmem [0:DELAY_FRAMES-1];
    logic [scd_pkg::PHASE_W-1:0]  r_pmem [0:PH_DEPTH-1];
    logic [2*SW-1:0]              r_dmem_q;
    logic [scd_pkg::PHASE_W-1:0]  r_ph_q;
    logic                         r_ph_qv;

    // datapath
    logic [SIW-1:0]           r_si;
    logic signed [SW-1:0]     r_sine;
    logic signed [DW-1:0]     r_d;
    logic [YW-1:0]            r_y;
    logic                     r_rd_ok;
    logic signed [2*SW-1:0]   r_pl, r_pr;
    logic signed [ACC_W-1:0]  r_acc_l, r_acc_r;
    logic [SW-1:0]            r_out_l, r_out_r;

    logic signed [SW-1:0] w_sine_rom [0:SINE_ENTRIES-1];

    logic                         w_in_acc;
    logic                         w_fin;
    logic                         w_load;
    logic                         w_act;
    logic [scd_pkg::PHASE_W-1:0]  w_phase;
    logic [scd_pkg::PHASE_W-1:0]  w_rate;
    logic [SPW-1:0]               w_si_prod;
    logic signed [scd_pkg::SWING_W:0] w_swing_s;
    logic signed [PRW-1:0]        w_sw_prod;
    logic signed [DW-1:0]         w_d;
    logic signed [DW-1:0]         w_d_adj;
    logic signed [DW-16:0]        w_dly;
    logic [YW-1:0]                w_y;
    logic [YW-1:0]                w_y1, w_y2, w_y3;
    logic [AW-1:0]                w_rd_addr;
    logic [2*SW-1:0]              w_smp;
    logic signed [SW-1:0]         w_smp_l, w_smp_r;
    logic signed [SW:0]           w_gain_s;
    logic signed [ACC_W-1:0]      w_rnd_l, w_rnd_r;
    logic signed [SHW-1:0]        w_sh_l, w_sh_r;
    logic [SW-1:0]                w_res_l, w_res_r;

    // sine table, one entry per quarter-wave polynomial evaluation
    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
        localparam longint G4 = 4 * g;
        localparam longint Q  = G4 / SINE_ENTRIES;
        localparam longint T  = ((G4 % SINE_ENTRIES) * 32768) / SINE_ENTRIES;
        localparam longint U  = (Q % 2 == 1) ? (32768 - T) : T;
        localparam longint U2 = (U * U) >> 15;
        localparam longint R1 = 21167 - ((2611 * U2) >> 15);
        localparam longint R2 = 51472 - ((R1 * U2) >> 15);
        localparam longint R3 = (R2 * U) >> 15;
        localparam longint V  = (R3 > 32767) ? 32767 : R3;
        localparam longint E  = (Q < 2) ? V : -V;
        assign w_sine_rom[g] = SW'(E);
    end

    assign s_axis_tready = (r_state == scd_pkg::ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_act         = int'(r_iss) < int'(r_vcount);

    // stage 1: phase, rate, sine index
    assign w_phase   = r_ph_qv ? r_ph_q : '0;
    assign w_si_prod = SPW'(w_phase) * SPW'(SINE_ENTRIES);

    always_comb begin
        w_rate = '0;
        for (int k = 0; k < scd_pkg::NUM_RATES; k++) begin
            if (int'(r_t1.voice) == k) begin
                w_rate = r_rate[k];
            end
        end
    end

    // stage 3: exact delay in Q15
    assign w_swing_s = {1'b0, r_swing};
    assign w_sw_prod = w_swing_s * r_sine;
    assign w_d       = DW'(w_sw_prod) + DW'({r_median, 15'd0});

    // stage 4: truncate toward zero, offset so the modulo stays non-negative
    assign w_d_adj = r_d + (r_d[DW-1] ? DW'(32767) : DW'(0));
    assign w_dly   = w_d_adj[DW-1:15];
    assign w_y     = YW'(r_wp) + YW'(OFFS3) - YW'(w_dly);

    // stage 5: reduce modulo the store depth
    assign w_y1      = (r_y  >= YW'(OFFS4)) ? (r_y  - YW'(OFFS4)) : r_y;
    assign w_y2      = (w_y1 >= YW'(OFFS2)) ? (w_y1 - YW'(OFFS2)) : w_y1;
    assign w_y3      = (w_y2 >= YW'(DELAY_FRAMES)) ? (w_y2 - YW'(DELAY_FRAMES)) : w_y2;
    assign w_rd_addr = AW'(w_y3);

    // stage 6: gain
    assign w_smp    = r_rd_ok ? r_dmem_q : '0;
    assign w_smp_l  = w_smp[SW-1:0];
    assign w_smp_r  = w_smp[2*SW-1:SW];
    assign w_gain_s = {1'b0, r_gain};

    // round and saturate
    assign w_rnd_l = r_acc_l + ACC_W'(16384);
    assign w_rnd_r = r_acc_r + ACC_W'(16384);
    assign w_sh_l  = w_rnd_l[ACC_W-1:15];
    assign w_sh_r  = w_rnd_r[ACC_W-1:15];

    always_comb begin
        if ((&w_sh_l[SHW-1:SW-1]) || !(|w_sh_l[SHW-1:SW-1])) begin
            w_res_l = w_sh_l[SW-1:0];
        end else if (w_sh_l[SHW-1]) begin
            w_res_l = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_res_l = {1'b0, {(SW-1){1'b1}}};
        end
        if ((&w_sh_r[SHW-1:SW-1]) || !(|w_sh_r[SHW-1:SW-1])) begin
            w_res_r = w_sh_r[SW-1:0];
        end else if (w_sh_r[SHW-1]) begin
            w_res_r = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_res_r = {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign w_fin  = ((r_state == scd_pkg::ST_RUN) && r_fin) || (r_state == scd_pkg::ST_HOLD);
    assign w_load = w_fin && (!r_ovld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        unique case (r_state)
            scd_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = scd_pkg::ST_RUN;
                end
            end
            scd_pkg::ST_RUN, scd_pkg::ST_HOLD: begin
                if (w_load) begin
                    n_state = scd_pkg::ST_IDLE;
                    n_wp    = (r_wp == AW'(DELAY_FRAMES - 1)) ? '0 : r_wp + AW'(1);
                end else if (w_fin) begin
                    n_state = scd_pkg::ST_HOLD;
                end
            end
            default: begin
                n_state = scd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= scd_pkg::ST_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_iss    <= '0;
            r_iss_on <= 1'b0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_t4     <= '0;
            r_t5     <= '0;
            r_t6     <= '0;
            r_t7     <= '0;
            r_fin    <= 1'b0;
            r_ovld   <= 1'b0;
            r_ph_vld <= '0;
            r_vcount <= scd_pkg::VOICE_COUNT_RST;
            r_gain   <= scd_pkg::VOICE_GAIN_RST;
            r_median <= scd_pkg::MEDIAN_RST;
            r_swing  <= scd_pkg::SWING_RST;
            for (int k = 0; k < scd_pkg::NUM_RATES; k++) begin
                r_rate[k] <= scd_pkg::RATE_RST[k];
            end
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;

            if (w_in_acc && (r_fill < FW'(DELAY_FRAMES))) begin
                r_fill <= r_fill + FW'(1);
            end

            // issue one voice a cycle
            if (w_in_acc) begin
                r_iss    <= '0;
                r_iss_on <= 1'b1;
            end else if (r_iss_on) begin
                if (r_iss == VW'(MAX_VOICES - 1)) begin
                    r_iss_on <= 1'b0;
                end else begin
                    r_iss <= r_iss + VW'(1);
                end
            end

            r_t1.vld   <= r_iss_on;
            r_t1.act   <= w_act;
            r_t1.last  <= (r_iss == VW'(MAX_VOICES - 1));
            r_t1.voice <= r_iss;
            r_t2       <= r_t1;
            r_t3       <= r_t2;
            r_t4       <= r_t3;
            r_t5       <= r_t4;
            r_t6       <= r_t5;
            r_t7       <= r_t6;
            r_fin      <= r_t7.vld && r_t7.last;

            if (r_t1.vld) begin
                r_ph_vld[r_t1.voice] <= 1'b1;
            end

            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (scd_pkg::t_cfg_idx'(i_cfg_idx))
                    scd_pkg::REG_VOICE_COUNT: r_vcount  <= i_cfg_wdata[scd_pkg::COUNT_W-1:0];
                    scd_pkg::REG_VOICE_GAIN:  r_gain    <= i_cfg_wdata[scd_pkg::GAIN_W-1:0];
                    scd_pkg::REG_MEDIAN:      r_median  <= i_cfg_wdata[scd_pkg::MEDIAN_W-1:0];
                    scd_pkg::REG_SWING:       r_swing   <= i_cfg_wdata[scd_pkg::SWING_W-1:0];
                    scd_pkg::REG_RATE_V0:     r_rate[0] <= i_cfg_wdata;
                    scd_pkg::REG_RATE_V1:     r_rate[1] <= i_cfg_wdata;
                    scd_pkg::REG_RATE_V2:     r_rate[2] <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // delay store: frame write on accept, voice read in stage 5
        if (w_in_acc) begin
            r_dmem[r_wp] <= s_axis_tdata[2*SW-1:0];
        end
        if (r_t5.vld) begin
            r_dmem_q <= r_dmem[w_rd_addr];
            r_rd_ok  <= FW'(w_rd_addr) < r_fill;
        end

        // phase store: read on issue, write back advanced phase in stage 1
        if (r_iss_on) begin
            r_ph_q  <= r_pmem[r_iss];
            r_ph_qv <= r_ph_vld[r_iss];
        end
        if (r_t1.vld) begin
            r_pmem[r_t1.voice] <= w_phase + w_rate;
        end

        r_si   <= w_si_prod[scd_pkg::PHASE_W +: SIW];
        r_sine <= w_sine_rom[r_si];
        r_d    <= w_d;
        r_y    <= w_y;
        r_pl   <= w_gain_s * w_smp_l;
        r_pr   <= w_gain_s * w_smp_r;

        if (w_in_acc) begin
            r_acc_l <= ACC_W'($signed({s_axis_tdata[3*SW-1:2*SW], 15'd0}));
            r_acc_r <= ACC_W'($signed({s_axis_tdata[4*SW-1:3*SW], 15'd0}));
        end else if (r_t7.vld && r_t7.act) begin
            r_acc_l <= r_acc_l + ACC_W'(r_pl);
            r_acc_r <= r_acc_r + ACC_W'(r_pr);
        end

        if (w_load) begin
            r_out_l <= w_res_l;
            r_out_r <= w_res_r;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_out_r, r_out_l};

endmodule

`default_nettype wire

// ===== bench/stereo_chorus_delay_test.sv =====
`timescale 1ns / 1ps

module stereo_chorus_delay_test;

    localparam int SAMPLE_W     = scd_pkg::SAMPLE_W;
    localparam int COUNT_W      = scd_pkg::COUNT_W;
    localparam int GAIN_W       = scd_pkg::GAIN_W;
    localparam int MEDIAN_W     = scd_pkg::MEDIAN_W;
    localparam int SWING_W      = scd_pkg::SWING_W;
    localparam int PHASE_W      = scd_pkg::PHASE_W;
    localparam int CFG_IDX_W    = scd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = scd_pkg::CFG_DATA_W;
    localparam int IN_DATA_W    = scd_pkg::IN_DATA_W;
    localparam int OUT_DATA_W   = scd_pkg::OUT_DATA_W;
    localparam int STORE_FRAMES = scd_pkg::DELAY_FRAMES_DEF;
    localparam int SINE_SIZE    = scd_pkg::SINE_ENTRIES_DEF;
    localparam int VOICES       = scd_pkg::MAX_VOICES_DEF;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] base_right;
        logic signed [SAMPLE_W-1:0] base_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic signed [SAMPLE_W-1:0] in_left;
    } t_chorus_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_right;
        logic signed [SAMPLE_W-1:0] out_left;
    } t_chorus_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    stereo_chorus_delay dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // chorus state and register copy
    shortint               sine_lut [SINE_SIZE];
    logic [31:0]           echo_store [STORE_FRAMES];
    logic [10:0]           echo_wr;
    logic [PHASE_W-1:0]    lfo_acc [VOICES];
    logic [PHASE_W-1:0]    lfo_step [VOICES];
    logic [COUNT_W-1:0]    cur_count;
    logic [GAIN_W-1:0]     cur_gain;
    logic [MEDIAN_W-1:0]   cur_median;
    logic [SWING_W-1:0]    cur_swing;

    t_chorus_frame         frames_pending [$];
    t_chorus_out           mix_expected [$];
    t_chorus_out           want;
    t_chorus_out           got;
    int                    frames_queued = 0;
    int                    frames_accepted = 0;
    int                    results_seen = 0;
    int                    mismatch_count = 0;
    int                    settings_run = 0;
    bit                    tx_gaps_on = 1'b0;
    bit                    rx_stalls_on = 1'b0;
    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    hold_left = 0;
    int                    next_hold_at = 300;
    int                    long_holds = 0;
    logic [15:0]           rx_pattern = 16'hFFFF;
    logic [3:0]            rx_pos = '0;

    function automatic void build_sine_lut();
        longint q, t, u, u2, r;
        for (int i = 0; i < SINE_SIZE; i++) begin
            q  = (4 * i) / SINE_SIZE;
            t  = (((4 * i) % SINE_SIZE) * 32768) / SINE_SIZE;
            u  = q[0] ? 32768 - t : t;
            u2 = (u * u) >> 15;
            r  = 21167 - ((2611 * u2) >> 15);
            r  = 51472 - ((r * u2) >> 15);
            r  = (r * u) >> 15;
            if (r > 32767) r = 32767;
            sine_lut[i] = (q < 2) ? shortint'(r) : shortint'(-r);
        end
    endfunction

    function automatic void chorus_reset();
        foreach (echo_store[i]) echo_store[i] = '0;
        echo_wr    = '0;
        cur_count  = scd_pkg::VOICE_COUNT_RST;
        cur_gain   = scd_pkg::VOICE_GAIN_RST;
        cur_median = scd_pkg::MEDIAN_RST;
        cur_swing  = scd_pkg::SWING_RST;
        for (int v = 0; v < VOICES; v++) begin
            lfo_acc[v]  = '0;
            lfo_step[v] = scd_pkg::RATE_RST[v];
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(longint acc);
        if (acc > 32767) return 16'sh7FFF;
        if (acc < -32768) return 16'sh8000;
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic t_chorus_out chorus_mix(t_chorus_frame f);
        t_chorus_out r;
        longint      acc_l, acc_r, d, dly, dm, rd;
        logic [31:0] w;
        int          active;
        echo_store[echo_wr] = {f.in_right, f.in_left};
        acc_l  = longint'(f.base_left) * 32768;
        acc_r  = longint'(f.base_right) * 32768;
        active = (cur_count > VOICES) ? VOICES : cur_count;
        for (int v = 0; v < active; v++) begin
            d   = longint'(cur_median) * 32768
                + longint'(cur_swing) * longint'(sine_lut[lfo_acc[v][31:22]]);
            dly = (d >= 0) ? (d >>> 15) : -((-d) >>> 15);
            dm  = dly % STORE_FRAMES;
            if (dm < 0) dm += STORE_FRAMES;
            rd  = (longint'(echo_wr) + STORE_FRAMES - dm) % STORE_FRAMES;
            w   = echo_store[rd];
            acc_l += longint'(cur_gain) * longint'($signed(w[15:0]));
            acc_r += longint'(cur_gain) * longint'($signed(w[31:16]));
        end
        r.out_left  = clip_sample((acc_l + 16384) >>> 15);
        r.out_right = clip_sample((acc_r + 16384) >>> 15);
        for (int v = 0; v < VOICES; v++) lfo_acc[v] += lfo_step[v];
        echo_wr = echo_wr + 1'b1;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            scd_pkg::REG_VOICE_COUNT: cur_count   = val[COUNT_W-1:0];
            scd_pkg::REG_VOICE_GAIN:  cur_gain    = val[GAIN_W-1:0];
            scd_pkg::REG_MEDIAN:      cur_median  = val[MEDIAN_W-1:0];
            scd_pkg::REG_SWING:       cur_swing   = val[SWING_W-1:0];
            scd_pkg::REG_RATE_V0:     lfo_step[0] = val;
            scd_pkg::REG_RATE_V1:     lfo_step[1] = val;
            scd_pkg::REG_RATE_V2:     lfo_step[2] = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic queue_frame(input int il, input int ir, input int bl, input int br);
        t_chorus_frame f;
        f.in_left    = il[SAMPLE_W-1:0];
        f.in_right   = ir[SAMPLE_W-1:0];
        f.base_left  = bl[SAMPLE_W-1:0];
        f.base_right = br[SAMPLE_W-1:0];
        frames_pending.push_back(f);
        frames_queued++;
    endtask

    // wait until every queued word has come back
    task automatic drain();
        while (results_seen < frames_queued) @(posedge i_clk);
    endtask

    function automatic int rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        case ($urandom_range(0, 7))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2, 3: s = s >>> $urandom_range(3, 12);
            default: ;
        endcase
        return int'(s);
    endfunction

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 200000);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                mix_expected.push_back(chorus_mix(s_axis_tdata));
                frames_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (frames_pending.size() > 0) begin
                    s_axis_tdata  <= frames_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0 && tx_gaps_on) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (mix_expected.size() == 0) begin
                    $error("unexpected output word %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = mix_expected.pop_front();
                    if (got.out_left !== want.out_left) begin
                        $error("out_left: expected %0d, got %0d", want.out_left, got.out_left);
                        mismatch_count++;
                    end
                    if (got.out_right !== want.out_right) begin
                        $error("out_right: expected %0d, got %0d",
                               want.out_right, got.out_right);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
            // hold off long enough for the block to back up onto its input
            if (hold_left == 0 && results_seen >= next_hold_at &&
                frames_pending.size() > 20) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 900;
                long_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!rx_stalls_on) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= rx_pattern[rx_pos];
                rx_pos = rx_pos + 1'b1;
                if (rx_pos == 0) begin
                    case ($urandom_range(0, 3))
                        0: rx_pattern = 16'hFFFF;
                        1: rx_pattern = 16'($urandom);
                        2: rx_pattern = 16'($urandom & $urandom);
                        default: rx_pattern = 16'($urandom | $urandom);
                    endcase
                end
            end
        end
    end

    initial begin
        int n;
        build_sine_lut();
        chorus_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: store still empty, output follows base
        queue_frame(32767, -32768, 0, -1);
        queue_frame(-1, 0, 32767, -32768);
        queue_frame(0, 0, 0, 0);
        queue_frame(12345, -12345, -32768, 32767);
        drain();

        // zero delay at full gain: current frame read back, saturate both ways
        write_reg(scd_pkg::REG_VOICE_COUNT, 32'd3);
        write_reg(scd_pkg::REG_VOICE_GAIN, 32'd32767);
        write_reg(scd_pkg::REG_MEDIAN, 32'd0);
        write_reg(scd_pkg::REG_SWING, 32'd0);
        write_reg(scd_pkg::REG_RATE_V0, 32'hFFFF_FFFF);
        write_reg(scd_pkg::REG_RATE_V1, 32'd0);
        write_reg(scd_pkg::REG_RATE_V2, 32'h8000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        queue_frame(32767, 32767, 32767, 32767);
        queue_frame(-32768, -32768, -32768, -32768);
        queue_frame(32767, -32768, -32768, 32767);
        queue_frame(1, -1, 0, 0);
        queue_frame(-1, 1, 0, 0);
        drain();

        // no voices
        write_reg(scd_pkg::REG_VOICE_COUNT, 32'd0);
        end_writes();
        queue_frame(32767, -32768, 100, -100);
        queue_frame(-32768, 32767, -32768, 32767);
        queue_frame(555, -555, 0, -1);
        drain();

        // swing beyond median: negative delays wrap
        write_reg(scd_pkg::REG_VOICE_COUNT, 32'd3);
        write_reg(scd_pkg::REG_VOICE_GAIN, 32'd16384);
        write_reg(scd_pkg::REG_MEDIAN, 32'd10);
        write_reg(scd_pkg::REG_SWING, 32'd1023);
        write_reg(scd_pkg::REG_RATE_V0, 32'h1000_0000);
        write_reg(scd_pkg::REG_RATE_V1, 32'h7FFF_FFFF);
        write_reg(scd_pkg::REG_RATE_V2, 32'h4000_0001);
        end_writes();
        for (int i = 0; i < 5; i++) queue_frame(rand_sample(), rand_sample(), 0, 0);
        drain();

        // delays past the end of the store wrap
        write_reg(scd_pkg::REG_MEDIAN, 32'd2047);
        end_writes();
        for (int i = 0; i < 4; i++)
            queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        drain();

        while (frames_queued < RANDOM_ITEMS) begin
            write_reg(scd_pkg::REG_VOICE_COUNT,
                      ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0: write_reg(scd_pkg::REG_VOICE_GAIN, 32'd0);
                1: write_reg(scd_pkg::REG_VOICE_GAIN, 32'd32767);
                default: write_reg(scd_pkg::REG_VOICE_GAIN, $urandom);
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(scd_pkg::REG_MEDIAN, 32'd0);
                1: write_reg(scd_pkg::REG_MEDIAN, 32'd2047);
                default: write_reg(scd_pkg::REG_MEDIAN, $urandom_range(0, 2047));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(scd_pkg::REG_SWING, 32'd0);
                1: write_reg(scd_pkg::REG_SWING, 32'd1023);
                default: write_reg(scd_pkg::REG_SWING, $urandom_range(0, 1023));
            endcase
            write_reg(scd_pkg::REG_RATE_V0, rand_rate());
            write_reg(scd_pkg::REG_RATE_V1, rand_rate());
            write_reg(scd_pkg::REG_RATE_V2, rand_rate());
            if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
            end_writes();
            tx_gaps_on   = (settings_run % 4 != 1) && $urandom_range(0, 3) != 0;
            rx_stalls_on = (settings_run % 4 != 1) && $urandom_range(0, 3) != 0;
            n = $urandom_range(160, 190);
            if (n > RANDOM_ITEMS - frames_queued) n = RANDOM_ITEMS - frames_queued;
            for (int i = 0; i < n; i++)
                queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (mix_expected.size() != 0) begin
            $error("%0d output words never arrived", mix_expected.size());
            mismatch_count++;
        end
        $display("Ran %0d frames through %0d register settings, %0d long output holds.",
                 frames_accepted, settings_run, long_holds);
        $display("Compared %0d output words left and right.", results_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
